[rtl/tsv_pkg.sv]
// Shared constants and helpers for the time segmented volume block.
package tsv_pkg;

  localparam int unsigned MAX_WINDOW  = 256;
  localparam int unsigned MAX_AVERAGE = 256;
  localparam int unsigned PRICE_BITS  = 20;

  localparam int unsigned VOL_W   = 20;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned TERM_W  = PRICE_BITS + 1 + VOL_W;
  localparam int unsigned TOT_W   = 49;
  localparam int unsigned SUM_W   = 57;
  localparam int unsigned TAW     = $clog2(MAX_WINDOW);
  localparam int unsigned SAW     = $clog2(MAX_AVERAGE);
  localparam int unsigned STEP_W  = $clog2(SUM_W + 1);

  localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(12);
  localparam logic [LEN_W-1:0] MA_RESET     = LEN_W'(6);

  // Register indexes of the configuration port.
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_MA_LENGTH     = 1'b1;

  // Map a raw length register to 1..max.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
                                                 input logic [LEN_W:0]   max);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if ({1'b0, v} > max) begin
      r = max[LEN_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/tsv_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tsv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tsv_div.sv]
// Iterative signed divide of the sum total by the average length, one bit a cycle.
module tsv_div
  import tsv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] dividend_i,
  input  logic [LEN_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [TOT_W-1:0] quotient_o
);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [SUM_W-1:0]  dvd_q;
  logic [LEN_W-1:0]  rem_q;
  logic [LEN_W-1:0]  dsr_q;
  logic [STEP_W-1:0] cnt_q;
  logic [TOT_W-1:0]  quo_q;
  logic [LEN_W:0]    trial;
  logic              qbit;
  logic [SUM_W-1:0]  quo_final;

  assign trial     = {rem_q, dvd_q[SUM_W-1]};
  assign qbit      = trial >= {1'b0, dsr_q};
  assign quo_final = {dvd_q[SUM_W-2:0], qbit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      dvd_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      cnt_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= dividend_i[SUM_W-1];
        dvd_q  <= dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
        rem_q  <= '0;
        dsr_q  <= divisor_i;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rem_q <= qbit ? LEN_W'(trial - {1'b0, dsr_q}) : trial[LEN_W-1:0];
        dvd_q <= quo_final;
        cnt_q <= cnt_q + STEP_W'(1);
        if (cnt_q == STEP_W'(SUM_W - 1)) begin
          // last step: fix the sign and hand the quotient over
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quo_q  <= neg_q ? TOT_W'(-quo_final) : TOT_W'(quo_final);
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/time_segmented_volume_with_average.sv]
// Top level: time segmented volume with moving average over RAM-held histories.
//
//  channel   | direction | transfer carries
//  s_axis    | in        | tdata: close_price, volume; tuser: restart
//  m_axis    | out       | tdata: segment_volume, segment_valid, nonnegative,
//            |           |        average, average_valid
//  cfg       | in        | cfg_addr_i selects window_length or ma_length
//
// One bar at a time. A bar passes the multiply, term and sum states, and the
// divide state when the average window is full, to the output register: the
// serial divider retires one quotient bit a cycle over the 57-bit sum total.
// Both histories live in synchronous RAMs; reads issue in the multiply state,
// ahead of each write, so an entry is never read and written in the same cycle.
// Reset clears totals, counts, pointers and the previous close; the RAMs need
// no clearing pass as counts gate every use of read data. A stalled output holds
// the finished bar in the output register; the next bar is taken meanwhile.
module time_segmented_volume_with_average
  import tsv_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // cfg port
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [LEN_W-1:0]     cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,   // [19:0] close_price, [39:20] volume
  input  logic                 s_axis_tuser,   // [0] restart
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [103:0]         m_axis_tdata    // [48:0] segment_volume,
                                               // [49] segment_valid, [50] nonnegative,
                                               // [99:51] average, [100] average_valid
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_TERM,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  logic [LEN_W-1:0]         window_len_q, ma_len_q;
  logic [LEN_W-1:0]         wl, ml;

  logic [PRICE_BITS-1:0]    close_q, prev_close_q;
  logic [VOL_W-1:0]         vol_q;
  logic                     have_prev_q;

  logic signed [TERM_W-1:0] term_q;
  logic signed [TOT_W-1:0]  term_total_q;
  logic [LEN_W-1:0]         term_count_q;
  logic [TAW-1:0]           term_head_q;
  logic signed [SUM_W-1:0]  sum_total_q;
  logic [LEN_W-1:0]         sum_count_q;
  logic [SAW-1:0]           sum_head_q;

  logic signed [TOT_W-1:0]  avg_q;
  logic                     avg_valid_q;
  logic                     out_valid_q;
  logic [103:0]             out_data_q;

  // history RAM ports
  logic                     term_we, sum_we, hist_re;
  logic [TAW-1:0]           term_raddr;
  logic [SAW-1:0]           sum_raddr;
  logic [TERM_W-1:0]        term_rdata;
  logic [TOT_W-1:0]         sum_rdata;

  // per-step next values
  logic signed [PRICE_BITS:0] diff;
  logic signed [TERM_W-1:0]   term_d;
  logic                       term_full;
  logic signed [TOT_W-1:0]    term_total_d;
  logic [LEN_W-1:0]           term_count_d;
  logic                       sum_step;
  logic                       sum_full;
  logic signed [SUM_W-1:0]    sum_total_d;
  logic [LEN_W-1:0]           sum_count_d;

  logic                       div_start, div_done;
  logic signed [TOT_W-1:0]    div_quo;

  logic                       in_xfer;
  logic                       out_free;

  assign wl = clamp_len(window_len_q, (LEN_W+1)'(MAX_WINDOW));
  assign ml = clamp_len(ma_len_q,     (LEN_W+1)'(MAX_AVERAGE));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // price change times volume; registered before it is summed
  assign diff   = $signed({1'b0, close_q}) - $signed({1'b0, prev_close_q});
  assign term_d = TERM_W'(diff * $signed({1'b0, vol_q}));

  // fetch the oldest entries of both windows while the product forms
  assign hist_re    = (state_q == ST_MUL);
  assign term_raddr = term_head_q - wl[TAW-1:0];
  assign sum_raddr  = sum_head_q - ml[SAW-1:0];

  // term window: drop the oldest term once full, then add the new one
  assign term_full    = term_count_q >= wl;
  assign term_count_d = term_full ? term_count_q : term_count_q + LEN_W'(1);
  assign term_total_d = term_total_q + TOT_W'(term_q)
                      - (term_full ? TOT_W'($signed(term_rdata)) : TOT_W'(0));
  assign term_we      = (state_q == ST_TERM) && have_prev_q;

  // sum window: only full-window segment volumes enter it
  assign sum_step    = have_prev_q && term_full;
  assign sum_full    = sum_count_q >= ml;
  assign sum_count_d = sum_step ? (sum_full ? sum_count_q : sum_count_q + LEN_W'(1))
                                : sum_count_q;
  assign sum_total_d = sum_step ? (sum_total_q + SUM_W'(term_total_q)
                                   - (sum_full ? SUM_W'($signed(sum_rdata)) : SUM_W'(0)))
                                : sum_total_q;
  assign sum_we      = (state_q == ST_SUM) && sum_step;

  assign div_start = (state_q == ST_SUM) && (sum_count_d >= ml);

  tsv_ram #(
    .WIDTH (TERM_W),
    .DEPTH (MAX_WINDOW)
  ) u_term_ram (
    .clk_i   (clk_i),
    .we_i    (term_we),
    .waddr_i (term_head_q),
    .wdata_i (term_q),
    .re_i    (hist_re),
    .raddr_i (term_raddr),
    .rdata_o (term_rdata)
  );

  tsv_ram #(
    .WIDTH (TOT_W),
    .DEPTH (MAX_AVERAGE)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_head_q),
    .wdata_i (term_total_q),
    .re_i    (hist_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  tsv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_total_d),
    .divisor_i  (ml),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_len_q <= WINDOW_RESET;
      ma_len_q     <= MA_RESET;
      close_q      <= '0;
      vol_q        <= '0;
      prev_close_q <= '0;
      have_prev_q  <= 1'b0;
      term_q       <= '0;
      term_total_q <= '0;
      term_count_q <= '0;
      term_head_q  <= '0;
      sum_total_q  <= '0;
      sum_count_q  <= '0;
      sum_head_q   <= '0;
      avg_q        <= '0;
      avg_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // length writes restart the affected windows; previous close is kept
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_WINDOW_LENGTH: begin
            window_len_q <= cfg_wdata_i;
            term_total_q <= '0;
            term_count_q <= '0;
            term_head_q  <= '0;
            sum_total_q  <= '0;
            sum_count_q  <= '0;
            sum_head_q   <= '0;
          end
          REG_MA_LENGTH: begin
            ma_len_q    <= cfg_wdata_i;
            sum_total_q <= '0;
            sum_count_q <= '0;
            sum_head_q  <= '0;
          end
          default: begin
          end
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            close_q <= s_axis_tdata[PRICE_BITS-1:0];
            vol_q   <= s_axis_tdata[20 +: VOL_W];
            // restart: forget the previous close and empty both windows
            if (s_axis_tuser) begin
              have_prev_q  <= 1'b0;
              prev_close_q <= '0;
              term_total_q <= '0;
              term_count_q <= '0;
              term_head_q  <= '0;
              sum_total_q  <= '0;
              sum_count_q  <= '0;
              sum_head_q   <= '0;
            end
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          term_q  <= term_d;
          state_q <= ST_TERM;
        end
        ST_TERM: begin
          if (have_prev_q) begin
            term_total_q <= term_total_d;
            term_count_q <= term_count_d;
            term_head_q  <= term_head_q + TAW'(1);
          end
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          sum_total_q  <= sum_total_d;
          sum_count_q  <= sum_count_d;
          if (sum_step) begin
            sum_head_q <= sum_head_q + SAW'(1);
          end
          prev_close_q <= close_q;
          have_prev_q  <= 1'b1;
          avg_q        <= '0;
          avg_valid_q  <= div_start;
          state_q      <= div_start ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_done) begin
            avg_q   <= div_quo;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'b000, avg_valid_q, avg_q, !term_total_q[TOT_W-1],
                            term_full, term_total_q};
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/tsv_checker.sv]
// Port-level checks for the time segmented volume block, bound to the top level.
module tsv_checker
  import tsv_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_we_i,
  input logic             cfg_addr_i,
  input logic [LEN_W-1:0] cfg_wdata_i,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [39:0]      s_axis_tdata,
  input logic             s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [103:0]     m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one bar at a time: no transfer in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  // colour flag follows the sign of the segment volume
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[50] == !m_axis_tdata[48]))
    else $error("nonnegative disagrees with segment volume sign");

  // a full average window needs a full term window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[100] |-> m_axis_tdata[49])
    else $error("average valid without segment valid");

  // average reads zero until its window is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[100] |-> (m_axis_tdata[99:51] == '0))
    else $error("average not zero while partial");

endmodule

bind time_segmented_volume_with_average tsv_checker u_tsv_checker (.*);

[tb/tb_time_segmented_volume_with_average.sv]
// Self-checking testbench for the time segmented volume block with moving average.
module tb_time_segmented_volume_with_average;
  timeunit 1ns;
  timeprecision 1ps;

  import tsv_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT  = 4000;  // cycles without any transfer
  localparam int unsigned SETTLE_CYCLES   = 8;     // idle gap before a register write
  localparam int unsigned TAIL_CYCLES     = 80;    // longer than the longest bar
  localparam int unsigned HOLD_OFF_CYCLES = 400;   // one long receiver stall
  localparam int unsigned HOLD_OFF_AFTER  = 400;   // results seen before that stall
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned DIRECTED_BARS   = 24;
  localparam int unsigned PHASES          = 8;

  // Largest single term: a full price swing at full volume, (2^20 - 1)^2.
  localparam longint FULL_TERM = 64'sd1099509530625;

  // Result transfer, laid out exactly as m_axis_tdata (MSB first).
  typedef struct packed {
    logic [2:0]       pad;
    logic             avg_ok;
    logic [TOT_W-1:0] avg;
    logic             nonneg;
    logic             seg_ok;
    logic [TOT_W-1:0] seg;
  } tsv_result_t;

  // One bar of stimulus; want holds a hand-worked result where typed is set.
  typedef struct {
    logic [PRICE_BITS-1:0] close;
    logic [VOL_W-1:0]      volume;
    logic                  restart;
    bit                    typed;
    tsv_result_t           want;
  } bar_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic                 cfg_addr_i;
  logic [LEN_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata;   // [19:0] close_price, [39:20] volume
  logic                 s_axis_tuser;   // [0] restart
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [103:0]         m_axis_tdata;   // [48:0] segment_volume, [49] segment_valid,
                                        // [50] nonnegative, [99:51] average,
                                        // [100] average_valid

  // Predictor state: register copies, previous close and both sliding windows.
  logic [LEN_W-1:0]      window_reg;
  logic [LEN_W-1:0]      ma_reg;
  logic [PRICE_BITS-1:0] last_close;
  bit                    have_last;
  longint                term_ring [MAX_WINDOW];
  longint                term_sum;
  int unsigned           term_fill;
  int unsigned           term_wr;
  longint                seg_ring [MAX_AVERAGE];
  longint                seg_sum;
  int unsigned           seg_fill;
  int unsigned           seg_wr;

  tsv_result_t           bar_results [$];   // expected results, oldest first
  bar_row_t              bar_plan [$];      // directed bars
  int unsigned           results_seen;
  int unsigned           mismatches;
  int unsigned           idle_cycles;
  logic [PRICE_BITS-1:0] walk_close;

  // Random phases: register values, which registers get written, bar count and
  // restart rate (one bar in N restarts, 0 for none). Two long-window phases get
  // no restarts so that they fill and the average comes out.
  int unsigned phase_window  [PHASES] = '{3, 1, 0, 511, 2, 0, 7, 256};
  int unsigned phase_ma      [PHASES] = '{2, 1, 0, 3, 300, 5, 0, 256};
  bit          phase_set_win [PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};
  bit          phase_set_ma  [PHASES] = '{1, 1, 1, 1, 1, 1, 0, 1};
  int unsigned phase_bars    [PHASES] = '{100, 50, 40, 270, 270, 80, 80, 40};
  int unsigned phase_restart [PHASES] = '{16, 8, 8, 0, 0, 16, 32, 8};

  time_segmented_volume_with_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // A zero length register behaves as one, anything above the depth as the depth.
  function automatic int unsigned effective_len(logic [LEN_W-1:0] v, int unsigned cap);
    if (v == '0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic void clear_term_window();
    term_sum  = 0;
    term_fill = 0;
    term_wr   = 0;
  endfunction

  function automatic void clear_seg_window();
    seg_sum  = 0;
    seg_fill = 0;
    seg_wr   = 0;
  endfunction

  // Advance the predictor by one bar and return the result it must produce.
  function automatic tsv_result_t step_tsv(logic [PRICE_BITS-1:0] close,
                                           logic [VOL_W-1:0] volume, logic restart);
    int unsigned wl;
    int unsigned ml;
    int unsigned oldest;
    longint      term;
    longint      mean;
    tsv_result_t r;
    wl = effective_len(window_reg, MAX_WINDOW);
    ml = effective_len(ma_reg, MAX_AVERAGE);
    if (restart) begin
      have_last  = 1'b0;
      last_close = '0;
      clear_term_window();
      clear_seg_window();
    end
    // The first bar after reset or restart only records its close.
    if (have_last) begin
      term = (longint'(close) - longint'(last_close)) * longint'(volume);
      if (term_fill >= wl) begin
        oldest = (term_wr + MAX_WINDOW - wl) % MAX_WINDOW;
        term_sum -= term_ring[oldest];
      end else begin
        term_fill++;
      end
      term_sum += term;
      term_ring[term_wr] = term;
      term_wr = (term_wr + 1) % MAX_WINDOW;
      // Only a full window's sum enters the average window.
      if (term_fill >= wl) begin
        if (seg_fill >= ml) begin
          oldest = (seg_wr + MAX_AVERAGE - ml) % MAX_AVERAGE;
          seg_sum -= seg_ring[oldest];
        end else begin
          seg_fill++;
        end
        seg_sum += term_sum;
        seg_ring[seg_wr] = term_sum;
        seg_wr = (seg_wr + 1) % MAX_AVERAGE;
      end
    end
    last_close = close;
    have_last  = 1'b1;
    mean = 0;
    if (seg_fill >= ml) mean = seg_sum / longint'(ml);   // truncates toward zero
    r        = '0;
    r.seg    = term_sum[TOT_W-1:0];
    r.seg_ok = term_fill >= wl;
    r.nonneg = term_sum >= 0;
    r.avg    = mean[TOT_W-1:0];
    r.avg_ok = seg_fill >= ml;
    return r;
  endfunction

  function automatic tsv_result_t known_result(longint seg, bit seg_ok, bit nonneg,
                                               longint avg, bit avg_ok);
    tsv_result_t r;
    r        = '0;
    r.seg    = seg[TOT_W-1:0];
    r.seg_ok = seg_ok;
    r.nonneg = nonneg;
    r.avg    = avg[TOT_W-1:0];
    r.avg_ok = avg_ok;
    return r;
  endfunction

  function automatic void add_bar(logic [PRICE_BITS-1:0] close, logic [VOL_W-1:0] volume,
                                  logic restart, bit typed, tsv_result_t want);
    bar_row_t row;
    row.close   = close;
    row.volume  = volume;
    row.restart = restart;
    row.typed   = typed;
    row.want    = want;
    bar_plan.push_back(row);
  endfunction

  // Offer one bar after a random gap and hold it until the block takes it.
  // Entered and left on a rising edge; valid stays high when no gap follows.
  task automatic transfer_bar(bar_row_t row);
    int unsigned pick;
    int unsigned gap;
    tsv_result_t predicted;
    pick = $urandom_range(0, 31);
    if (pick < 16)      gap = 0;
    else if (pick < 29) gap = $urandom_range(1, 3);
    else if (pick < 31) gap = $urandom_range(4, 10);
    else                gap = $urandom_range(40, 150);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {row.volume, row.close};
    s_axis_tuser  <= row.restart;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = step_tsv(row.close, row.volume, row.restart);
    bar_results.push_back(row.typed ? row.want : predicted);
  endtask

  // Drop valid, wait for every expected result, then let the block settle.
  task automatic drain_results(int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (bar_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write one length register; the predictor clears its windows the same way.
  task automatic write_length(logic addr, logic [LEN_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    if (addr == REG_WINDOW_LENGTH) begin
      window_reg = value;
      clear_term_window();
      clear_seg_window();
    end else begin
      ma_reg = value;
      clear_seg_window();
    end
  endtask

  // Result checker: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    tsv_result_t got;
    tsv_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      results_seen++;
      if (bar_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result %0d arrived with no bar outstanding: %h", results_seen, got);
      end else begin
        want = bar_results.pop_front();
        if (got.seg !== want.seg || got.seg_ok !== want.seg_ok ||
            got.nonneg !== want.nonneg || got.avg !== want.avg ||
            got.avg_ok !== want.avg_ok || got.pad !== want.pad) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("result %0d mismatch: expected seg %0d ok %0b nn %0b avg %0d ok %0b pad %h",
                     results_seen, $signed(want.seg), want.seg_ok, want.nonneg,
                     $signed(want.avg), want.avg_ok, want.pad);
            $display("  got seg %0d ok %0b nn %0b avg %0d ok %0b pad %h",
                     $signed(got.seg), got.seg_ok, got.nonneg, $signed(got.avg),
                     got.avg_ok, got.pad);
          end
        end
      end
    end
  end

  // Watchdog: end the run if neither stream moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[time_segmented_volume_with_average] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver pacing: bursts of ready, short stalls, the odd long stall, and one
  // long hold-off in the middle of a long phase so that the block backs up.
  initial begin : sink_pacing
    int unsigned pick;
    bit          held_off;
    held_off = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      pick = $urandom_range(0, 15);
      if (pick < 4) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ((pick == 15) ? $urandom_range(20, 80) : $urandom_range(1, 3)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
  end

  initial begin
    bar_row_t    row;
    int unsigned pick;
    int          next_close;
    // Known values on every input before the first edge.
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = REG_WINDOW_LENGTH;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    results_seen  = 0;
    mismatches    = 0;
    idle_cycles   = 0;
    walk_close    = PRICE_BITS'(20'h80000);
    window_reg    = WINDOW_RESET;
    ma_reg        = MA_RESET;
    last_close    = '0;
    have_last     = 1'b0;
    clear_term_window();
    clear_seg_window();

    // Directed bars under the reset lengths (window 12, average 6). Full price
    // swings at full volume give the largest terms of either sign.
    add_bar(20'h00000, 20'h00000, 1'b0, 1, known_result(0, 0, 1, 0, 0));   // first bar
    add_bar(20'hFFFFF, 20'hFFFFF, 1'b0, 1, known_result(FULL_TERM, 0, 1, 0, 0));
    add_bar(20'h00000, 20'hFFFFF, 1'b0, 1, known_result(0, 0, 1, 0, 0));
    add_bar(20'h00000, 20'hFFFFF, 1'b1, 1, known_result(0, 0, 1, 0, 0));   // restart
    add_bar(20'hFFFFF, 20'hFFFFF, 1'b0, 1, known_result(FULL_TERM, 0, 1, 0, 0));
    add_bar(20'hFFFFF, 20'h00000, 1'b0, 1, known_result(FULL_TERM, 0, 1, 0, 0));
    add_bar(20'h00000, 20'hFFFFF, 1'b0, 1, known_result(0, 0, 1, 0, 0));
    add_bar(20'hFFFFF, 20'h00000, 1'b0, 1, known_result(0, 0, 1, 0, 0));
    add_bar(20'h00000, 20'hFFFFF, 1'b0, 1, known_result(-FULL_TERM, 0, 0, 0, 0));
    // Fill the term window (full at the twelfth term), then the average window.
    add_bar(20'h80000, 20'h7FFFF, 1'b0, 0, '0);
    add_bar(20'h7FFFF, 20'h80000, 1'b0, 0, '0);
    add_bar(20'hFFFFF, 20'hFFFFF, 1'b0, 0, '0);
    add_bar(20'h00001, 20'hFFFFF, 1'b0, 0, '0);
    add_bar(20'h55555, 20'hAAAAA, 1'b0, 0, '0);
    add_bar(20'hAAAAA, 20'h55555, 1'b0, 0, '0);
    add_bar(20'hFFFFF, 20'hFFFFF, 1'b0, 0, '0);
    add_bar(20'h00000, 20'hFFFFF, 1'b0, 0, '0);
    add_bar(20'hFFFFF, 20'hFFFFF, 1'b0, 0, '0);
    add_bar(20'h00000, 20'hFFFFF, 1'b0, 0, '0);
    add_bar(20'h12345, 20'h00001, 1'b0, 0, '0);
    add_bar(20'h12345, 20'h6789A, 1'b0, 0, '0);
    add_bar(20'h00000, 20'hFFFFF, 1'b0, 0, '0);
    // Restart with both windows full drops everything back to the first bar.
    add_bar(20'h00309, 20'hFFFFF, 1'b1, 1, known_result(0, 0, 1, 0, 0));
    add_bar(20'h00000, 20'h00000, 1'b0, 0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_BARS; i++) transfer_bar(bar_plan[i]);

    // Random phases: write the lengths with the block idle, then stream bars
    // whose close mostly wanders in small steps, with odd jumps at random or to a rail.
    for (int p = 0; p < PHASES; p++) begin
      drain_results(SETTLE_CYCLES);
      if (phase_set_win[p]) write_length(REG_WINDOW_LENGTH, LEN_W'(phase_window[p]));
      if (phase_set_ma[p])  write_length(REG_MA_LENGTH, LEN_W'(phase_ma[p]));
      cfg_we_i <= 1'b0;
      for (int n = 0; n < phase_bars[p]; n++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          walk_close = PRICE_BITS'($urandom);
        end else if (pick == 1) begin
          walk_close = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end else begin
          next_close = int'(walk_close) + int'($urandom_range(0, 2000)) - 1000;
          if (next_close < 0)                          walk_close = '0;
          else if (next_close > int'(20'hFFFFF))       walk_close = '1;
          else                                         walk_close = PRICE_BITS'(next_close);
        end
        row.close = walk_close;
        pick = $urandom_range(0, 7);
        case (pick)
          0:       row.volume = '1;
          1:       row.volume = VOL_W'($urandom);
          2:       row.volume = '0;
          default: row.volume = VOL_W'($urandom_range(1, 5000));
        endcase
        row.restart = (phase_restart[p] != 0) &&
                      ($urandom_range(0, phase_restart[p] - 1) == 0);
        row.typed   = 0;
        row.want    = '0;
        transfer_bar(row);
      end
    end

    // Wait out every outstanding result, plus the longest bar, then judge.
    drain_results(TAIL_CYCLES);
    if (mismatches == 0 && bar_results.size() == 0) begin
      $display("[time_segmented_volume_with_average] OK");
    end else begin
      $display("[time_segmented_volume_with_average] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/tsv_pkg.sv
rtl/tsv_ram.sv
rtl/tsv_div.sv
rtl/time_segmented_volume_with_average.sv
rtl/tsv_checker.sv
tb/tb_time_segmented_volume_with_average.sv
